// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication check.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/sobel_em_pkg.sv =====
package sobel_em_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CSR_W      = 13;
   localparam int PIX_W      = 8;
   localparam int LSUM_W     = PIX_W + 2;     // weighted sum of three taps
   localparam int GRAD_W     = PIX_W + 3;     // signed gradient
   localparam int PROD_W     = 2 * GRAD_W;
   localparam int SQ_W       = 20;            // 1020^2 fits in 20 bits
   localparam int SUM_W      = SQ_W + 1;
   localparam int RAD_W      = 2 * PIX_W;     // radicand when not saturated
   localparam int REM_W      = PIX_W + 3;
   localparam int ROOT_STEPS = PIX_W;
   localparam int STEP_W     = $clog2(ROOT_STEPS);
   localparam int SAT_LIMIT  = 65025;
   localparam int SAT_VALUE  = 255;
   localparam int MIN_DIM    = 3;

   // Register indexes
   localparam logic CSR_LINE_WIDTH   = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic read;
      logic square;
      logic sum;
      logic root;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic root_last;
   } status_type;

endpackage

// ===== rtl/sobel_em_ram.sv =====
module sobel_em_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sobel_em_ctrl.sv =====
`include "assert_macros.svh"

module sobel_em_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  sobel_em_pkg::status_type status,
   output sobel_em_pkg::cmd_type    cmd
);

   sobel_em_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // State and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sobel_em_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         sobel_em_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sobel_em_pkg::ST_READ;
            end
         end
         sobel_em_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = status.emit ? sobel_em_pkg::ST_SQUARE : sobel_em_pkg::ST_IDLE;
         end
         sobel_em_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = sobel_em_pkg::ST_SUM;
         end
         sobel_em_pkg::ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = sobel_em_pkg::ST_ROOT;
         end
         sobel_em_pkg::ST_ROOT: begin
            cmd.root = 1'b1;
            if (status.root_last) begin
               state_in = sobel_em_pkg::ST_OUTPUT;
            end
         end
         sobel_em_pkg::ST_OUTPUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = sobel_em_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sobel_em_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold the result while stalled, drop it once taken
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   `ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, !rsp_valid_ff || !rsp_stall)
   `ASSERT_NXT(a_accept_reads, clock, reset, cmd.accept, state_ff == sobel_em_pkg::ST_READ)
   `ASSERT_NXT(a_root_done, clock, reset, cmd.root && status.root_last,
      state_ff == sobel_em_pkg::ST_OUTPUT)
   `ASSERT_NXT(a_load_valid, clock, reset, cmd.out_load, rsp_valid_ff)

endmodule

// ===== rtl/sobel_em_dp.sv =====
`include "assert_macros.svh"

module sobel_em_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic                                  csr_index,
   input  logic [sobel_em_pkg::CSR_W-1:0]        csr_wdata,
   input  logic [sobel_em_pkg::PIX_W-1:0]        req_pixel,
   input  sobel_em_pkg::cmd_type                 cmd,
   output sobel_em_pkg::status_type              status,
   output logic [sobel_em_pkg::PIX_W-1:0]        rsp_edge_value,
   output logic [sobel_em_pkg::ROW_W-1:0]        rsp_center_row,
   output logic [sobel_em_pkg::COL_W-1:0]        rsp_center_col,
   output logic                                  rsp_frame_last
);

   localparam int COL_W  = sobel_em_pkg::COL_W;
   localparam int ROW_W  = sobel_em_pkg::ROW_W;
   localparam int CSR_W  = sobel_em_pkg::CSR_W;
   localparam int PIX_W  = sobel_em_pkg::PIX_W;
   localparam int LSUM_W = sobel_em_pkg::LSUM_W;
   localparam int GRAD_W = sobel_em_pkg::GRAD_W;
   localparam int PROD_W = sobel_em_pkg::PROD_W;
   localparam int SQ_W   = sobel_em_pkg::SQ_W;
   localparam int SUM_W  = sobel_em_pkg::SUM_W;
   localparam int RAD_W  = sobel_em_pkg::RAD_W;
   localparam int REM_W  = sobel_em_pkg::REM_W;
   localparam int STEP_W = sobel_em_pkg::STEP_W;

   // Configuration registers
   logic [CSR_W-1:0] line_width_ff, frame_height_ff;
   logic [COL_W-1:0] w_last;
   logic [ROW_W-1:0] h_last;

   // Position counters and latched transaction
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [PIX_W-1:0] px_ff;
   logic             emit_ff, last_ff;

   // Line stores and window
   logic [PIX_W-1:0] store_a_rd, store_b_rd;
   logic [PIX_W-1:0] win_ff [6];

   // Arithmetic
   logic [LSUM_W-1:0]        sum_r, sum_l, sum_t, sum_b;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic signed [PROD_W-1:0] prod_x, prod_y;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic [SUM_W-1:0]         mag_sum;
   logic                     sat_ff;
   logic [RAD_W-1:0]         rad_ff;
   logic [PIX_W-1:0]         root_ff, root_in;
   logic [REM_W-1:0]         rem_ff, rem_in, rem_sh, trial;
   logic [STEP_W-1:0]        step_ff;

   // Output registers
   logic [PIX_W-1:0] edge_ff;
   logic [ROW_W-1:0] out_row_ff;
   logic [COL_W-1:0] out_col_ff;
   logic             out_last_ff;

   // Clamp register values to the supported range, minus one
   always_comb begin
      if (line_width_ff < CSR_W'(sobel_em_pkg::MIN_DIM)) begin
         w_last = COL_W'(sobel_em_pkg::MIN_DIM - 1);
      end else if (line_width_ff > CSR_W'(sobel_em_pkg::MAX_WIDTH)) begin
         w_last = COL_W'(sobel_em_pkg::MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(line_width_ff - CSR_W'(1));
      end
      if (frame_height_ff < CSR_W'(sobel_em_pkg::MIN_DIM)) begin
         h_last = ROW_W'(sobel_em_pkg::MIN_DIM - 1);
      end else if (frame_height_ff > CSR_W'(sobel_em_pkg::MAX_HEIGHT)) begin
         h_last = ROW_W'(sobel_em_pkg::MAX_HEIGHT - 1);
      end else begin
         h_last = ROW_W'(frame_height_ff - CSR_W'(1));
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= CSR_W'(sobel_em_pkg::MAX_WIDTH);
         frame_height_ff <= CSR_W'(sobel_em_pkg::MAX_HEIGHT);
      end else if (csr_write) begin
         case (csr_index)
            sobel_em_pkg::CSR_LINE_WIDTH:   line_width_ff   <= csr_wdata;
            sobel_em_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance raster position
   always_comb begin
      col_count_in = col_count_ff + COL_W'(1);
      row_count_in = row_count_ff;
      if (col_count_ff >= w_last) begin
         col_count_in = '0;
         row_count_in = (row_count_ff >= h_last) ? '0 : row_count_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         emit_ff      <= 1'b0;
      end else if (cmd.accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         emit_ff      <= (row_count_ff >= ROW_W'(2)) && (col_count_ff >= COL_W'(2));
      end
   end

   // Latch the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff   <= req_pixel;
         col_ff  <= col_count_ff;
         row_ff  <= row_count_ff;
         last_ff <= (row_count_ff >= h_last) && (col_count_ff >= w_last);
      end
   end

   // Line store a holds the previous row, b the one above it
   sobel_em_ram #(.WIDTH(PIX_W), .DEPTH(sobel_em_pkg::MAX_WIDTH)) u_store_a (
      .clock   (clock),
      .wr_en   (cmd.read),
      .wr_addr (col_ff),
      .wr_data (px_ff),
      .rd_en   (cmd.accept),
      .rd_addr (col_count_ff),
      .rd_data (store_a_rd)
   );

   sobel_em_ram #(.WIDTH(PIX_W), .DEPTH(sobel_em_pkg::MAX_WIDTH)) u_store_b (
      .clock   (clock),
      .wr_en   (cmd.read),
      .wr_addr (col_ff),
      .wr_data (store_a_rd),
      .rd_en   (cmd.accept),
      .rd_addr (col_count_ff),
      .rd_data (store_b_rd)
   );

   // Weighted column and row sums of the 3x3 window
   assign sum_r = LSUM_W'(store_b_rd) + {1'b0, store_a_rd, 1'b0} + LSUM_W'(px_ff);
   assign sum_l = LSUM_W'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + LSUM_W'(win_ff[2]);
   assign sum_t = LSUM_W'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + LSUM_W'(store_b_rd);
   assign sum_b = LSUM_W'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + LSUM_W'(px_ff);

   // Form gradients and shift the window by one column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.read) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= store_b_rd;
         win_ff[4] <= store_a_rd;
         win_ff[5] <= px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         gx_ff <= $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
         gy_ff <= $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
      end
   end

   // Square the gradients
   assign prod_x = gx_ff * gx_ff;
   assign prod_y = gy_ff * gy_ff;

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sqx_ff <= prod_x[SQ_W-1:0];
         sqy_ff <= prod_y[SQ_W-1:0];
      end
   end

   assign mag_sum = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);

   // One root bit per step, two radicand bits consumed each step
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {root_ff[PIX_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {root_ff[PIX_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         sat_ff  <= mag_sum >= SUM_W'(sobel_em_pkg::SAT_LIMIT);
         rad_ff  <= mag_sum[RAD_W-1:0];
         root_ff <= '0;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.root) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         root_ff <= root_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   assign status.emit      = emit_ff;
   assign status.root_last = step_ff == STEP_W'(sobel_em_pkg::ROOT_STEPS - 1);

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         edge_ff     <= sat_ff ? PIX_W'(sobel_em_pkg::SAT_VALUE) : root_ff;
         out_row_ff  <= row_ff - ROW_W'(1);
         out_col_ff  <= col_ff - COL_W'(1);
         out_last_ff <= last_ff;
      end
   end

   assign rsp_edge_value = edge_ff;
   assign rsp_center_row = out_row_ff;
   assign rsp_center_col = out_col_ff;
   assign rsp_frame_last = out_last_ff;

   `ASSERT_IMP(a_load_interior, clock, reset, cmd.out_load, emit_ff)
   `ASSERT_NXT(a_sum_clears, clock, reset, cmd.sum, step_ff == '0 && root_ff == '0)

endmodule

// ===== rtl/sobel_edge_magnitude_top.sv =====
// 3x3 Sobel gradient magnitude over a raster pixel stream.
// Input channel req_*: one grey pixel per transaction in raster order, taken
// when req_valid is high and req_stall is low. Result channel rsp_*: one
// transaction per interior pixel (border positions give none) carrying the
// saturated floor square root of gx^2 + gy^2, the window center position and
// a flag on the last interior result of the frame.
// csr_write with csr_index selects line_width (0) or frame_height (1); values
// are clamped to 3..4096. Write only while the block is idle.
// Each pixel is handled by a controller stepping a shared datapath: a border
// pixel passes through accept and line store read (with the sums); an interior
// pixel also through squaring, sum, a one-bit-per-step square root unit and
// output load. rsp_valid is registered and rises once the result is loaded.
// The result sits in an output register, so the next pixel is accepted while
// a stalled result waits; a second result waits in the datapath until the
// first is taken, and req_stall stays high meanwhile.
// Reset (synchronous, active high) restores both dimensions to 4096, returns
// the position to row 0 column 0 and drops any pending result. Line store
// contents are not cleared; each entry is written before its value is used in a frame.
module sobel_edge_magnitude_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic                               csr_index,
   input  logic [sobel_em_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sobel_em_pkg::PIX_W-1:0]     req_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sobel_em_pkg::PIX_W-1:0]     rsp_edge_value,
   output logic [sobel_em_pkg::ROW_W-1:0]     rsp_center_row,
   output logic [sobel_em_pkg::COL_W-1:0]     rsp_center_col,
   output logic                               rsp_frame_last
);

   sobel_em_pkg::cmd_type    cmd;
   sobel_em_pkg::status_type status;

   sobel_em_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sobel_em_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_pixel      (req_pixel),
      .cmd            (cmd),
      .status         (status),
      .rsp_edge_value (rsp_edge_value),
      .rsp_center_row (rsp_center_row),
      .rsp_center_col (rsp_center_col),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
